### hdl/dtv_pkg.sv
// Shared types, constants and helper functions of the date text validator.
`default_nettype none
package dtv_pkg;

  localparam int TEXT_LENGTH = 10;
  localparam int COUNT_W     = 4;
  localparam logic [COUNT_W-1:0] COUNT_LEN = COUNT_W'(TEXT_LENGTH);
  localparam logic [COUNT_W-1:0] COUNT_MAX = COUNT_W'(TEXT_LENGTH + 1);

  localparam logic [7:0] CH_DASH  = 8'h2D;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  localparam logic [1:0] REG_YEAR   = 2'd0;
  localparam logic [1:0] REG_MONTH  = 2'd1;
  localparam logic [1:0] REG_DAY    = 2'd2;
  localparam logic [1:0] REG_FUTURE = 2'd3;

  localparam logic [1:0] STATUS_EMPTY   = 2'd0;
  localparam logic [1:0] STATUS_VALID   = 2'd1;
  localparam logic [1:0] STATUS_INVALID = 2'd2;
  localparam logic [1:0] STATUS_FUTURE  = 2'd3;

  typedef logic [7:0] char_t;

  typedef struct packed {
    logic [COUNT_W-1:0]              count;
    logic [TEXT_LENGTH-1:0][7:0]     text;
  } item_t;

  typedef struct packed {
    logic [13:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic        allow_future;
  } cfg_t;

  function automatic logic is_digit(input char_t c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

  function automatic logic [3:0] digit_val(input char_t c);
    return c[3:0];
  endfunction

  function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
    logic [4:0] len;
    case (m)
      4'd2:                      len = leap ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:   len = 5'd30;
      default:                   len = 5'd31;
    endcase
    return len;
  endfunction

endpackage
`default_nettype wire

### hdl/date_text_validator.sv
// Date text validator: takes a date one character per item and, at each end item, returns
// status (empty, valid, invalid, future) with the parsed year, month and day. One item is
// taken every cycle while the queue is not full. Each end item is snapshotted into a
// two-entry queue and checked by a two-stage back end; its result passes through the queue,
// the stage-1 register and the output register. in_ready drops only when the queue is full
// because results are not being taken. Formats: YYYY-MM-DD, DD.MM.YYYY, DD/MM/YYYY.
// Write the today and allow_future registers only while no value is in flight.
`default_nettype none
module date_text_validator (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [13:0] cfg_data,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        in_kind,
  input  wire logic [7:0]  in_char_code,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [1:0]       out_status,
  output logic [13:0]      out_parsed_year,
  output logic [6:0]       out_parsed_month,
  output logic [6:0]       out_parsed_day
);
  import dtv_pkg::*;

  cfg_t  cfg_r;
  logic  in_acc, push, q_full, q_valid, q_pop;
  item_t push_item, q_item;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.year         <= 14'd2000;
      cfg_r.month        <= 4'd1;
      cfg_r.day          <= 5'd1;
      cfg_r.allow_future <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_YEAR:   cfg_r.year         <= cfg_data;
        REG_MONTH:  cfg_r.month        <= cfg_data[3:0];
        REG_DAY:    cfg_r.day          <= cfg_data[4:0];
        REG_FUTURE: cfg_r.allow_future <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign in_ready = !q_full;
  assign in_acc   = in_valid && in_ready;

  dtv_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .acc       (in_acc),
    .kind      (in_kind),
    .char_code (in_char_code),
    .push      (push),
    .push_item (push_item)
  );

  dtv_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .full      (q_full),
    .pop_valid (q_valid),
    .pop       (q_pop),
    .pop_item  (q_item)
  );

  dtv_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg              (cfg_r),
    .q_valid          (q_valid),
    .q_item           (q_item),
    .q_pop            (q_pop),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_status       (out_status),
    .out_parsed_year  (out_parsed_year),
    .out_parsed_month (out_parsed_month),
    .out_parsed_day   (out_parsed_day)
  );

endmodule
`default_nettype wire

### hdl/dtv_front.sv
// Front end: takes character items into the text buffer and queues a snapshot on each end item.
`default_nettype none
module dtv_front (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          acc,
  input  wire logic          kind,
  input  wire dtv_pkg::char_t char_code,
  output logic               push,
  output dtv_pkg::item_t     push_item
);
  import dtv_pkg::*;

  logic [COUNT_W-1:0] count_r, count_nxt;
  char_t              buf_r [TEXT_LENGTH];

  always_comb begin
    count_nxt = count_r;
    if (acc) begin
      if (kind) begin
        count_nxt = '0;
      end else if (count_r < COUNT_MAX) begin
        count_nxt = count_r + COUNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (acc && !kind && (count_r < COUNT_LEN)) begin
      buf_r[count_r] <= char_code;
    end
  end

  assign push = acc && kind;

  always_comb begin
    push_item.count = count_r;
    for (int i = 0; i < TEXT_LENGTH; i++) begin
      push_item.text[i] = buf_r[i];
    end
  end

endmodule
`default_nettype wire

### hdl/dtv_queue.sv
// Two-entry queue of closed values between front and back end.
`default_nettype none
module dtv_queue (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           push,
  input  wire dtv_pkg::item_t push_item,
  output logic                full,
  output logic                pop_valid,
  input  wire logic           pop,
  output dtv_pkg::item_t      pop_item
);
  import dtv_pkg::*;

  item_t       mem_r [2];
  logic        wr_ptr_r, wr_ptr_nxt;
  logic        rd_ptr_r, rd_ptr_nxt;
  logic [1:0]  cnt_r, cnt_nxt;
  logic        do_push, do_pop;

  assign full      = (cnt_r == 2'd2);
  assign pop_valid = (cnt_r != 2'd0);
  assign do_push   = push && !full;
  assign do_pop    = pop && pop_valid;
  assign pop_item  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = do_push ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = do_pop ? !rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

endmodule
`default_nettype wire

### hdl/dtv_back.sv
// Back end: parses the text in one stage, checks calendar and today's date in the next.
`default_nettype none
module dtv_back (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire dtv_pkg::cfg_t  cfg,
  input  wire logic           q_valid,
  input  wire dtv_pkg::item_t q_item,
  output logic                q_pop,
  output logic                out_valid,
  input  wire logic           out_ready,
  output logic [1:0]          out_status,
  output logic [13:0]         out_parsed_year,
  output logic [6:0]          out_parsed_month,
  output logic [6:0]          out_parsed_day
);
  import dtv_pkg::*;

  typedef struct packed {
    logic        empty;
    logic        parse_ok;
    logic        leap;
    logic [13:0] year;
    logic [6:0]  month;
    logic [6:0]  day;
  } parse_t;

  parse_t      s1_r, s1_nxt;
  logic        s1_valid_r;
  logic        out_valid_r;
  logic [1:0]  status_r, status_nxt;
  logic [13:0] year_r, year_nxt;
  logic [6:0]  month_r, month_nxt;
  logic [6:0]  day_r, day_nxt;
  logic        out_free, s1_load, out_load;

  // stage 1: format and digits
  logic        iso, eu, len_ok, dig_ok;
  logic [6:0]  hh, yy, mm, dd;
  logic [3:0]  p_hh0, p_hh1, p_yy0, p_yy1, p_m0, p_m1, p_d0, p_d1;
  char_t       sep;

  always_comb begin
    sep    = q_item.text[2];
    len_ok = (q_item.count == COUNT_LEN);
    iso    = (q_item.text[4] == CH_DASH) && (q_item.text[7] == CH_DASH);
    eu     = ((sep == CH_DOT) || (sep == CH_SLASH)) && (q_item.text[5] == sep);
    if (iso) begin
      dig_ok = is_digit(q_item.text[0]) && is_digit(q_item.text[1]) &&
               is_digit(q_item.text[2]) && is_digit(q_item.text[3]) &&
               is_digit(q_item.text[5]) && is_digit(q_item.text[6]) &&
               is_digit(q_item.text[8]) && is_digit(q_item.text[9]);
      p_hh0 = digit_val(q_item.text[0]);
      p_hh1 = digit_val(q_item.text[1]);
      p_yy0 = digit_val(q_item.text[2]);
      p_yy1 = digit_val(q_item.text[3]);
      p_m0  = digit_val(q_item.text[5]);
      p_m1  = digit_val(q_item.text[6]);
      p_d0  = digit_val(q_item.text[8]);
      p_d1  = digit_val(q_item.text[9]);
    end else begin
      dig_ok = is_digit(q_item.text[0]) && is_digit(q_item.text[1]) &&
               is_digit(q_item.text[3]) && is_digit(q_item.text[4]) &&
               is_digit(q_item.text[6]) && is_digit(q_item.text[7]) &&
               is_digit(q_item.text[8]) && is_digit(q_item.text[9]);
      p_d0  = digit_val(q_item.text[0]);
      p_d1  = digit_val(q_item.text[1]);
      p_m0  = digit_val(q_item.text[3]);
      p_m1  = digit_val(q_item.text[4]);
      p_hh0 = digit_val(q_item.text[6]);
      p_hh1 = digit_val(q_item.text[7]);
      p_yy0 = digit_val(q_item.text[8]);
      p_yy1 = digit_val(q_item.text[9]);
    end
    hh = 7'(p_hh0) * 7'd10 + 7'(p_hh1);
    yy = 7'(p_yy0) * 7'd10 + 7'(p_yy1);
    mm = 7'(p_m0) * 7'd10 + 7'(p_m1);
    dd = 7'(p_d0) * 7'd10 + 7'(p_d1);

    s1_nxt.empty    = (q_item.count == '0);
    s1_nxt.parse_ok = len_ok && (iso || eu) && dig_ok;
    // 100 and 400 are multiples of 4, so the low digit pairs decide
    s1_nxt.leap     = (yy == 7'd0) ? (hh[1:0] == 2'd0) : (yy[1:0] == 2'd0);
    s1_nxt.year     = 14'(hh) * 14'd100 + 14'(yy);
    s1_nxt.month    = mm;
    s1_nxt.day      = dd;
  end

  // stage 2: calendar and today check
  logic        range_ok, later;
  logic [4:0]  mlen;

  always_comb begin
    mlen     = month_len(s1_r.month[3:0], s1_r.leap);
    range_ok = (s1_r.year != 14'd0) && (s1_r.month >= 7'd1) && (s1_r.month <= 7'd12) &&
               (s1_r.day >= 7'd1) && (s1_r.day <= 7'(mlen));
    if (s1_r.year != cfg.year) begin
      later = s1_r.year > cfg.year;
    end else if (s1_r.month != 7'(cfg.month)) begin
      later = s1_r.month > 7'(cfg.month);
    end else begin
      later = s1_r.day > 7'(cfg.day);
    end

    year_nxt  = s1_r.year;
    month_nxt = s1_r.month;
    day_nxt   = s1_r.day;
    if (s1_r.empty || !s1_r.parse_ok) begin
      year_nxt  = '0;
      month_nxt = '0;
      day_nxt   = '0;
    end
    if (s1_r.empty) begin
      status_nxt = STATUS_EMPTY;
    end else if (!s1_r.parse_ok || !range_ok) begin
      status_nxt = STATUS_INVALID;
    end else if (!cfg.allow_future && later) begin
      status_nxt = STATUS_FUTURE;
    end else begin
      status_nxt = STATUS_VALID;
    end
  end

  assign out_free = !out_valid_r || out_ready;
  assign out_load = s1_valid_r && out_free;
  assign s1_load  = !s1_valid_r || out_free;
  assign q_pop    = q_valid && s1_load;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (s1_load) begin
        s1_valid_r <= q_valid;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      s1_r <= s1_nxt;
    end
    if (out_load) begin
      status_r <= status_nxt;
      year_r   <= year_nxt;
      month_r  <= month_nxt;
      day_r    <= day_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_status       = status_r;
  assign out_parsed_year  = year_r;
  assign out_parsed_month = month_r;
  assign out_parsed_day   = day_r;

endmodule
`default_nettype wire

### hdl/dtv_checker.sv
// Port-level checks of the date text validator, bound to the top level.
`default_nettype none
module dtv_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [1:0]  out_status,
  input wire logic [13:0] out_parsed_year,
  input wire logic [6:0]  out_parsed_month,
  input wire logic [6:0]  out_parsed_day
);
  import dtv_pkg::*;

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status) &&
      $stable(out_parsed_year) && $stable(out_parsed_month) && $stable(out_parsed_day))
    else $error("result changed while stalled");

  a_reset: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  a_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == STATUS_EMPTY) |->
      (out_parsed_year == 14'd0) && (out_parsed_month == 7'd0) && (out_parsed_day == 7'd0))
    else $error("empty result with nonzero fields");

  a_real_date: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && ((out_status == STATUS_VALID) || (out_status == STATUS_FUTURE)) |->
      (out_parsed_year != 14'd0) && (out_parsed_month >= 7'd1) &&
      (out_parsed_month <= 7'd12) && (out_parsed_day >= 7'd1) && (out_parsed_day <= 7'd31))
    else $error("accepted date out of calendar range");

endmodule

bind date_text_validator dtv_checker u_dtv_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .out_status       (out_status),
  .out_parsed_year  (out_parsed_year),
  .out_parsed_month (out_parsed_month),
  .out_parsed_day   (out_parsed_day)
);
`default_nettype wire
